// ===== sv/selective_repeat_arq_sender_top_defines.svh =====
// ----------------------------------------------------------------------------
// Selective repeat ARQ sender assertion macros
// Concurrent assertion wrappers shared by the sender RTL.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_ARQ_SENDER_TOP_DEFINES_SVH
`define SELECTIVE_REPEAT_ARQ_SENDER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// check a property on every clock edge outside reset
`define SRA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check that a condition is followed by another one in the next cycle
`define SRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SRA_ASSERT(lbl, clk, rst_n, prop, msg)
`define SRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== sv/sra_pkg.sv =====
// ----------------------------------------------------------------------------
// Selective repeat ARQ sender package
// Shared constants, codes and types of the sender.
// ----------------------------------------------------------------------------
package sra_pkg;

    localparam int WINDOW_MAX = 16;
    localparam int STREAM_MAX = 128;
    localparam int LIST_AW    = $clog2(WINDOW_MAX);
    localparam int IDX_W      = 7;
    localparam int CNT_W      = 5;
    localparam int POS_W      = 8;

    typedef enum logic [1:0] {
        RESP_ACK = 2'd0,
        RESP_NAK = 2'd1
    } resp_t;

    typedef enum logic [1:0] {
        CFG_WINDOW_SIZE   = 2'd0,
        CFG_STREAM_LENGTH = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        logic               en;
        logic [LIST_AW-1:0] addr;
        logic [IDX_W-1:0]   data;
    } list_wr_t;

    // first member sits in the top bits, so answered_index lands in bit 0
    typedef struct packed {
        logic             done_res;
        logic             next_is_resend;
        logic [IDX_W-1:0] next_index;
        logic [POS_W-1:0] window_ack_index;
        logic             window_ack_valid;
        logic [CNT_W-1:0] failed_count;
        logic             answered_failed;
        logic             answered_ok;
        logic [IDX_W-1:0] answered_index;
    } result_t;

endpackage

// ===== sv/sra_list.sv =====
// ----------------------------------------------------------------------------
// Failed frame list
// Register array of negatively acknowledged frame indices with one write
// port, one read port and a forwarded view of the head entry.
// ----------------------------------------------------------------------------
module sra_list
    import sra_pkg::*;
(
    input  logic               clk,
    input  list_wr_t           wr,
    input  logic [LIST_AW-1:0] rd_addr,
    output logic [IDX_W-1:0]   rd_data,
    output logic [IDX_W-1:0]   head_data
);

    logic [IDX_W-1:0] list_mem [WINDOW_MAX];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            list_mem[wr.addr] <= wr.data;
        end
    end

    assign rd_data = list_mem[rd_addr];

    // head entry as it stands after this cycle's write
    assign head_data = (wr.en && (wr.addr == '0)) ? wr.data : list_mem[0];

endmodule

// ===== sv/selective_repeat_arq_sender_top.sv =====
// ----------------------------------------------------------------------------
// Selective repeat ARQ sender
// Walks windows of frames, collects negative answers, resends the failed
// frames until the list is empty and emits cumulative window acks.
// ----------------------------------------------------------------------------
//
//  channel  direction  signals                     payload
//  -------  ---------  --------------------------  ------------------------------
//  s_*      in         s_tvalid s_tready s_tdata   response answer for offered frame
//  m_*      out        m_tvalid m_tready m_tdata   one result item per answer
//  cfg_*    in         cfg_valid cfg_ready         cfg_index, cfg_data register write
//
//  Each answer item is processed in the cycle it is accepted and its result is
//  held in the output register in the next cycle; one item per cycle unless m_tready stalls.
//  The only limit on rate is the single output register: a new item is taken
//  whenever the output register is empty or being drained in the same cycle.
//  Reset clears all progress; the stream length resets to zero, so the block
//  starts finished and answers with done_res until stream_length is written.
//  Configuration writes are always taken (cfg_ready is tied high).
//
`include "selective_repeat_arq_sender_top_defines.svh"

module selective_repeat_arq_sender_top
    import sra_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // answers: [1:0] response, [7:2] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // results: [6:0] answered_index, [7] answered_ok, [8] answered_failed,
    // [13:9] failed_count, [14] window_ack_valid, [22:15] window_ack_index,
    // [29:23] next_index, [30] next_is_resend, [31] done_res
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    // ---------------------------------------------------------------- state
    logic [4:0]       window_size_reg;
    logic [7:0]       stream_length_reg;
    logic [POS_W-1:0] window_base_reg,   window_base_next;
    logic [POS_W-1:0] send_position_reg, send_position_next;
    logic             resend_phase_reg,  resend_phase_next;
    logic [CNT_W-1:0] failed_total_reg,  failed_total_next;
    logic [CNT_W-1:0] resend_read_reg,   resend_read_next;
    logic [CNT_W-1:0] resend_write_reg,  resend_write_next;
    logic             finished_reg,      finished_next;
    logic [IDX_W-1:0] offer_reg,         offer_next;

    logic             out_valid_reg;
    result_t          out_data_reg;

    // ---------------------------------------------------------------- step logic
    logic             s_accept;
    logic             cfg_accept;
    logic [1:0]       resp;
    logic [4:0]       win_eff;
    logic [POS_W-1:0] len_eff;
    logic [POS_W:0]   window_end;
    logic             window_done;
    logic [CNT_W-1:0] read_inc;
    logic [CNT_W-1:0] write_inc;
    logic [CNT_W-1:0] pending;
    result_t          res;
    list_wr_t         step_wr;
    list_wr_t         list_wr;
    logic [IDX_W-1:0] list_rd_data;
    logic [IDX_W-1:0] list_head;

    assign s_accept   = s_tvalid && s_tready;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign resp       = s_tdata[1:0];

    // hold a new answer only while the output register cannot drain
    assign s_tready  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // clamp the window to 1 .. WINDOW_MAX and the length to STREAM_MAX
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            win_eff = 5'd1;
        end
        else if (window_size_reg > 5'(WINDOW_MAX))
        begin
            win_eff = 5'(WINDOW_MAX);
        end
        else
        begin
            win_eff = window_size_reg;
        end
        len_eff = (stream_length_reg > 8'(STREAM_MAX)) ? 8'(STREAM_MAX) : stream_length_reg;
    end

    assign window_end = {1'b0, window_base_reg} + {4'b0, win_eff};
    assign read_inc   = resend_read_reg + 5'd1;

    // list write for this answer: append in the first pass, compact during resend
    always_comb
    begin
        step_wr = '0;
        if (!finished_reg)
        begin
            if (!resend_phase_reg)
            begin
                step_wr.en   = (resp == RESP_NAK) && (failed_total_reg < 5'(WINDOW_MAX));
                step_wr.addr = failed_total_reg[LIST_AW-1:0];
                step_wr.data = send_position_reg[IDX_W-1:0];
            end
            else if (resp == RESP_NAK)
            begin
                step_wr.en   = !resend_write_reg[CNT_W-1];
                step_wr.addr = resend_write_reg[LIST_AW-1:0];
                step_wr.data = offer_reg;
            end
        end
    end

    always_comb
    begin
        window_base_next   = window_base_reg;
        send_position_next = send_position_reg;
        resend_phase_next  = resend_phase_reg;
        failed_total_next  = failed_total_reg;
        resend_read_next   = resend_read_reg;
        resend_write_next  = resend_write_reg;
        finished_next      = finished_reg;
        offer_next         = offer_reg;
        window_done        = 1'b0;
        write_inc          = resend_write_reg;
        pending            = '0;
        res                = '0;

        if (finished_reg)
        begin
            // keep state, report done only
            res.done_res = 1'b1;
        end
        else
        begin
            if (!resend_phase_reg)
            begin
                // first pass over the window
                res.answered_index  = send_position_reg[IDX_W-1:0];
                res.answered_ok     = (resp == RESP_ACK);
                res.answered_failed = (resp == RESP_NAK);
                failed_total_next  = failed_total_reg + {4'b0, step_wr.en};
                res.failed_count   = failed_total_next;
                send_position_next = send_position_reg + 8'd1;
                if (({1'b0, send_position_next} >= window_end) ||
                    (send_position_next >= len_eff))
                begin
                    if (failed_total_next != '0)
                    begin
                        resend_phase_next  = 1'b1;
                        resend_read_next   = '0;
                        resend_write_next  = '0;
                        res.next_index     = list_head;
                        res.next_is_resend = 1'b1;
                    end
                    else
                    begin
                        if (send_position_next < len_eff)
                        begin
                            res.window_ack_valid = 1'b1;
                            res.window_ack_index = send_position_next;
                        end
                        window_done = 1'b1;
                    end
                end
                else
                begin
                    res.next_index = send_position_next[IDX_W-1:0];
                end
            end
            else
            begin
                // resend pass: compact survivors toward the list head
                res.answered_index = offer_reg;
                if (resp == RESP_NAK)
                begin
                    res.answered_failed = 1'b1;
                    write_inc    = resend_write_reg + 5'd1;
                end
                else
                begin
                    res.answered_ok = 1'b1;
                end
                pending = (failed_total_reg > read_inc) ? (failed_total_reg - read_inc) : '0;
                res.failed_count  = write_inc + pending;
                resend_read_next  = read_inc;
                resend_write_next = write_inc;
                if (read_inc >= failed_total_reg)
                begin
                    failed_total_next = write_inc;
                    resend_read_next  = '0;
                    resend_write_next = '0;
                    if (write_inc == '0)
                    begin
                        resend_phase_next = 1'b0;
                        window_done       = 1'b1;
                    end
                    else
                    begin
                        res.next_index     = list_head;
                        res.next_is_resend = 1'b1;
                    end
                end
                else
                begin
                    res.next_index     = list_rd_data;
                    res.next_is_resend = 1'b1;
                end
            end

            if (window_done)
            begin
                // advance the base past the finished window
                window_base_next   = send_position_next;
                res.next_is_resend = 1'b0;
                if (send_position_next >= len_eff)
                begin
                    finished_next  = 1'b1;
                    res.next_index = '0;
                end
                else
                begin
                    res.next_index = send_position_next[IDX_W-1:0];
                end
            end
            res.done_res = finished_next;
            offer_next   = res.next_index;
        end
    end

    // write the list only for an accepted answer
    always_comb
    begin
        list_wr    = step_wr;
        list_wr.en = step_wr.en && s_accept;
    end

    sra_list u_list
    (
        .clk       (clk),
        .wr        (list_wr),
        .rd_addr   (read_inc[LIST_AW-1:0]),
        .rd_data   (list_rd_data),
        .head_data (list_head)
    );

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg   <= 5'd4;
            stream_length_reg <= '0;
            window_base_reg   <= '0;
            send_position_reg <= '0;
            resend_phase_reg  <= 1'b0;
            failed_total_reg  <= '0;
            resend_read_reg   <= '0;
            resend_write_reg  <= '0;
            finished_reg      <= 1'b1;
            offer_reg         <= '0;
        end
        else if (cfg_accept)
        begin
            unique case (cfg_index)
                CFG_WINDOW_SIZE:
                begin
                    window_size_reg <= cfg_data[4:0];
                end
                CFG_STREAM_LENGTH:
                begin
                    // restart the stream from frame zero
                    stream_length_reg <= cfg_data;
                    window_base_reg   <= '0;
                    send_position_reg <= '0;
                    resend_phase_reg  <= 1'b0;
                    failed_total_reg  <= '0;
                    resend_read_reg   <= '0;
                    resend_write_reg  <= '0;
                    finished_reg      <= (cfg_data == '0);
                    offer_reg         <= '0;
                end
                default:
                begin
                    // unused register index, drop the write
                end
            endcase
        end
        else if (s_accept)
        begin
            window_base_reg   <= window_base_next;
            send_position_reg <= send_position_next;
            resend_phase_reg  <= resend_phase_next;
            failed_total_reg  <= failed_total_next;
            resend_read_reg   <= resend_read_next;
            resend_write_reg  <= resend_write_next;
            finished_reg      <= finished_next;
            offer_reg         <= offer_next;
        end
    end

    // output register: load on accept, clear valid when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------------------------------------------------------- assertions
    `SRA_ASSERT(a_list_bound, clk, rst_n, failed_total_reg <= 5'(WINDOW_MAX), "failed list overflow")
    `SRA_ASSERT(a_compact_order, clk, rst_n, resend_write_reg <= resend_read_reg, "compaction overtook read pointer")
    `SRA_ASSERT(a_resend_nonempty, clk, rst_n, !resend_phase_reg || (resend_read_reg < failed_total_reg), "resend pass past list end")
    `SRA_ASSERT(a_done_idle, clk, rst_n, !finished_reg || !resend_phase_reg, "resend pass after stream done")
    `SRA_ASSERT_NEXT(a_done_result, clk, rst_n, s_accept && finished_reg, m_tvalid && m_tdata[31], "answer after done lost its done flag")

endmodule

// ===== test/tb_selective_repeat_arq_sender_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective repeat ARQ sender testbench
// Drives receiver answers into the sender and keeps a cycle-free model of the
// window, resend list and stream progress. Each result item is compared
// field by field with the prediction made when its answer was accepted.
// Directed cases come first, then random streams with random idling on
// both sides.
// ----------------------------------------------------------------------------
module tb_selective_repeat_arq_sender_top;
    import sra_pkg::*;

    // answer codes with no member in the package: both count as "other key"
    localparam logic [1:0] OTHER_KEY     = 2'd2;
    localparam logic [1:0] OTHER_KEY_ALT = 2'd3;
    // register index with no register behind it
    localparam logic [1:0] CFG_UNUSED    = 2'd3;

    localparam int unsigned RANDOM_ITEMS = 1400;
    localparam int unsigned PHASE_CAP    = 300;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    // ------------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;

    selective_repeat_arq_sender_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sender model state: registers, window progress and the failed-frame list
    // ------------------------------------------------------------------------
    logic [4:0]       win_size_reg;
    logic [7:0]       stream_len_reg;
    logic [POS_W-1:0] base;
    logic [POS_W-1:0] pos;
    logic             resending;
    logic [IDX_W-1:0] retry_list [WINDOW_MAX];
    logic [CNT_W-1:0] fail_total;
    logic [CNT_W-1:0] rd;
    logic [CNT_W-1:0] wr;
    logic             stream_done;

    result_t pending_results [$];

    // run bookkeeping
    int unsigned mismatches    = 0;
    int unsigned answers_sent  = 0;
    int unsigned random_sent   = 0;
    int unsigned reg_writes    = 0;
    int unsigned results_seen  = 0;
    int unsigned acks_seen     = 0;
    int unsigned resends_seen  = 0;
    int unsigned cycle_count   = 0;

    // idling controls, changed per test
    bit          tx_gaps   = 1'b0;
    bit          rx_stalls = 1'b0;
    int unsigned rx_hold   = 0;

    // window size register: 0 acts as 1, anything above the list depth as the depth
    function automatic int unsigned window_in_use();
        if (win_size_reg == 0)
            return 1;
        if (win_size_reg > WINDOW_MAX)
            return WINDOW_MAX;
        return win_size_reg;
    endfunction

    function automatic int unsigned frames_in_stream();
        if (stream_len_reg > STREAM_MAX)
            return STREAM_MAX;
        return stream_len_reg;
    endfunction

    // start over at frame 0; an empty stream is finished at once
    function automatic void clear_progress();
        base        = '0;
        pos         = '0;
        resending   = 1'b0;
        fail_total  = '0;
        rd          = '0;
        wr          = '0;
        for (int k = 0; k < WINDOW_MAX; k++)
            retry_list[k] = '0;
        stream_done = (frames_in_stream() == 0);
    endfunction

    function automatic void apply_reg_write(input logic [1:0] idx, input logic [7:0] value);
        if (idx == CFG_WINDOW_SIZE)
        begin
            win_size_reg = value[4:0];
        end
        else if (idx == CFG_STREAM_LENGTH)
        begin
            stream_len_reg = value;
            clear_progress();
        end
    endfunction

    // Advance the model by one answer and return the result item it must cause.
    function automatic result_t predict_answer(input logic [1:0] resp);
        result_t          r;
        int unsigned      win;
        int unsigned      len;
        logic [IDX_W-1:0] frame;
        logic             window_closed;
        r             = '0;
        win           = window_in_use();
        len           = frames_in_stream();
        window_closed = 1'b0;
        if (stream_done)
        begin
            r.done_res = 1'b1;
            return r;
        end
        if (!resending)
        begin
            // first pass: list a lost frame, let an other-key answer drop through
            frame             = pos[IDX_W-1:0];
            r.answered_index  = frame;
            r.answered_ok     = (resp == RESP_ACK);
            r.answered_failed = (resp == RESP_NAK);
            if (resp == RESP_NAK && fail_total < WINDOW_MAX)
            begin
                retry_list[fail_total] = frame;
                fail_total++;
            end
            r.failed_count = fail_total;
            pos++;
            if (pos >= base + win || pos >= len)
            begin
                if (fail_total != 0)
                begin
                    resending        = 1'b1;
                    rd               = '0;
                    wr               = '0;
                    r.next_index     = retry_list[0];
                    r.next_is_resend = 1'b1;
                end
                else
                begin
                    if (pos < len)
                    begin
                        r.window_ack_valid = 1'b1;
                        r.window_ack_index = pos;
                    end
                    window_closed = 1'b1;
                end
            end
            else
            begin
                r.next_index = pos[IDX_W-1:0];
            end
        end
        else
        begin
            // resend: frames lost again are compacted to the front of the list
            frame            = retry_list[rd];
            r.answered_index = frame;
            if (resp == RESP_NAK)
            begin
                r.answered_failed = 1'b1;
                if (wr < WINDOW_MAX)
                    retry_list[wr] = frame;
                wr++;
            end
            else
            begin
                r.answered_ok = 1'b1;
            end
            rd++;
            r.failed_count = wr + ((fail_total > rd) ? fail_total - rd : 0);
            if (rd >= fail_total)
            begin
                fail_total = wr;
                rd         = '0;
                wr         = '0;
                if (fail_total == 0)
                begin
                    resending     = 1'b0;
                    window_closed = 1'b1;
                end
                else
                begin
                    r.next_index     = retry_list[0];
                    r.next_is_resend = 1'b1;
                end
            end
            else
            begin
                r.next_index     = retry_list[rd];
                r.next_is_resend = 1'b1;
            end
        end
        if (window_closed)
        begin
            base = pos;
            if (pos >= len)
            begin
                stream_done  = 1'b1;
                r.next_index = '0;
            end
            else
            begin
                r.next_index = pos[IDX_W-1:0];
            end
            r.next_is_resend = 1'b0;
        end
        r.done_res = stream_done;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // idle length: mostly none, sometimes short, rarely a long stretch
    function automatic int unsigned idle_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return 0;
        if (pick < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [1:0] random_response(input int unsigned nak_pct,
                                                   input int unsigned other_pct);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < other_pct)
            return $urandom_range(0, 1) ? OTHER_KEY : OTHER_KEY_ALT;
        if (pick < other_pct + nak_pct)
            return RESP_NAK;
        return RESP_ACK;
    endfunction

    // Offer one answer item and hold it until taken. Valid stays high after the
    // handshake so back-to-back items never drop it; a gap lowers it first.
    task automatic send_answer(input logic [1:0] resp);
        int unsigned gap;
        gap = tx_gaps ? idle_length() : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, resp};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(predict_answer(resp));
        answers_sent++;
    endtask

    // Hold the sender until every predicted result has been taken, then let
    // the output register settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    // valid stays high across back-to-back writes; cfg_release drops it
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg_write(idx, value);
        reg_writes++;
    endtask

    task automatic cfg_release();
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and the checker
    // ------------------------------------------------------------------------

    // alternate ready and stalled stretches while stalls are enabled
    always @(posedge clk)
    begin
        if (!rx_stalls)
        begin
            m_tready <= 1'b1;
            rx_hold  <= 0;
        end
        else if (rx_hold != 0)
        begin
            rx_hold <= rx_hold - 1;
        end
        else if (m_tready)
        begin
            m_tready <= 1'b0;
            rx_hold  <= idle_length();
        end
        else
        begin
            m_tready <= 1'b1;
            rx_hold  <= $urandom_range(0, 8);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    result_t got_result;
    result_t want_result;

    // compare every taken result item with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_result = m_tdata;
            results_seen++;
            if (got_result.window_ack_valid)
                acks_seen++;
            if (got_result.next_is_resend)
                resends_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result item 0x%08h arrived with no answer pending", m_tdata);
                mismatches++;
            end
            else
            begin
                want_result = pending_results.pop_front();
                check_field("answered_index", want_result.answered_index,
                            got_result.answered_index);
                check_field("answered_ok", want_result.answered_ok, got_result.answered_ok);
                check_field("answered_failed", want_result.answered_failed,
                            got_result.answered_failed);
                check_field("failed_count", want_result.failed_count,
                            got_result.failed_count);
                check_field("window_ack_valid", want_result.window_ack_valid,
                            got_result.window_ack_valid);
                check_field("window_ack_index", want_result.window_ack_index,
                            got_result.window_ack_index);
                check_field("next_index", want_result.next_index, got_result.next_index);
                check_field("next_is_resend", want_result.next_is_resend,
                            got_result.next_is_resend);
                check_field("done_res", want_result.done_res, got_result.done_res);
            end
        end
    end

    // hard stop if the run hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_selective_repeat_arq_sender_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Out of reset the stream is empty: every answer reports done and nothing
    // else. A write to an index with no register must change nothing.
    task automatic test_idle_after_reset();
        write_reg(CFG_UNUSED, 8'hFF);
        cfg_release();
        send_answer(RESP_ACK);
        send_answer(OTHER_KEY_ALT);
        drain_results();
    endtask

    // Window 4 over 6 frames, all received: one cumulative ack after the
    // first window, none after the last. Pause mid-stream until all results
    // are in, and answer once more after the stream is done.
    task automatic test_clean_windows();
        write_reg(CFG_WINDOW_SIZE, 8'd4);
        write_reg(CFG_STREAM_LENGTH, 8'd6);
        cfg_release();
        repeat (4) send_answer(RESP_ACK);
        drain_results();
        repeat (2) send_answer(RESP_ACK);
        send_answer(RESP_NAK);
        drain_results();
    endtask

    // Lost frames go to the list, an other key skips a frame in the first
    // pass but counts as received during resend, and a frame lost again is
    // kept for another round. Run with back-pressure on the result side.
    task automatic test_resend_rounds();
        rx_stalls = 1'b1;
        write_reg(CFG_STREAM_LENGTH, 8'd4);
        cfg_release();
        send_answer(RESP_NAK);
        send_answer(OTHER_KEY);
        send_answer(RESP_NAK);
        send_answer(RESP_ACK);
        send_answer(RESP_NAK);
        send_answer(OTHER_KEY);
        send_answer(RESP_ACK);
        send_answer(RESP_ACK);
        drain_results();
        rx_stalls = 1'b0;
    endtask

    // Register extremes: window 0 (upper data bits set) acts as 1, window 31
    // acts as the list depth, length 255 is clamped, and the second length
    // write restarts the stream mid-way.
    task automatic test_register_extremes();
        write_reg(CFG_WINDOW_SIZE, 8'hE0);
        write_reg(CFG_STREAM_LENGTH, 8'd255);
        cfg_release();
        send_answer(RESP_ACK);
        send_answer(RESP_NAK);
        send_answer(RESP_ACK);
        drain_results();

        write_reg(CFG_WINDOW_SIZE, 8'h1F);
        write_reg(CFG_STREAM_LENGTH, 8'd3);
        cfg_release();
        repeat (3) send_answer(OTHER_KEY_ALT);
        drain_results();

        write_reg(CFG_WINDOW_SIZE, 8'd16);
        write_reg(CFG_STREAM_LENGTH, 8'd1);
        cfg_release();
        send_answer(RESP_NAK);
        send_answer(RESP_NAK);
        send_answer(RESP_ACK);
        drain_results();
    endtask

    // Random streams: pick window and length (extremes included), a loss
    // rate and idling per phase, then answer until the stream is done or the
    // phase cap is hit. Answers after done are noise and are not counted.
    task automatic test_random_streams();
        int unsigned      phase_items;
        int unsigned      nak_pct;
        int unsigned      other_pct;
        int unsigned      pick;
        logic [4:0]       win;
        logic [7:0]       len;
        while (random_sent < RANDOM_ITEMS)
        begin
            drain_results();
            tx_gaps   = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);

            case ($urandom_range(0, 9))
                0:       win = 5'd0;
                1:       win = 5'd31;
                2:       win = 5'd16;
                3:       win = 5'd1;
                default: win = 5'($urandom_range(2, 17));
            endcase
            pick = $urandom_range(0, 19);
            if (pick == 0)
                len = 8'd255;
            else if (pick == 1)
                len = 8'd128;
            else if (pick == 2)
                len = 8'($urandom_range(100, 200));
            else if (pick == 3)
                len = 8'd0;
            else
                len = 8'($urandom_range(1, 24));

            // now and then change only the window, leaving the stream running
            write_reg(CFG_WINDOW_SIZE, {3'($urandom_range(0, 7)), win});
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_STREAM_LENGTH, len);
            if ($urandom_range(0, 15) == 0)
                write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
            cfg_release();

            case ($urandom_range(0, 3))
                0:       nak_pct = 5;
                1:       nak_pct = 25;
                2:       nak_pct = 50;
                default: nak_pct = 90;
            endcase
            other_pct = $urandom_range(0, 1) ? 0 : 6;

            phase_items = 0;
            while (!stream_done && phase_items < PHASE_CAP && random_sent < RANDOM_ITEMS)
            begin
                send_answer(random_response(nak_pct, other_pct));
                phase_items++;
                random_sent++;
                if ($urandom_range(0, 63) == 0)
                    drain_results();
            end
            if (stream_done && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) send_answer(random_response(50, 20));
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        win_size_reg   = 5'd4;
        stream_len_reg = 8'd0;
        clear_progress();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_after_reset();
        test_clean_windows();
        test_resend_rounds();
        test_register_extremes();
        test_random_streams();

        // nothing pending now; leave room for a stray late result
        repeat (8) @(posedge clk);

        $display("covered %0d answers (%0d in random streams) and %0d register writes",
                 answers_sent, random_sent, reg_writes);
        $display("checked %0d results: %0d window acks, %0d resend offers",
                 results_seen, acks_seen, resends_seen);
        if (mismatches == 0)
            $display("tb_selective_repeat_arq_sender_top: PASS");
        else
            $display("tb_selective_repeat_arq_sender_top: FAIL");
        $finish;
    end

endmodule
